// ===== hdl/eaq_pkg.sv =====
// Shared constants and types for the Euler-angle to quaternion pipeline.
// No dependencies; imported by every eaq_* module and the top level.
package eaq_pkg;

    localparam int ATAN_COUNT      = 30;
    localparam int ITER_FRAC       = 30;
    localparam int HALF_TURN_UNITS = 46080;   // one turn of the half angle, 1/128 deg
    localparam int DIV_45          = 45;      // 46080 = 45 * 2^10
    localparam int RECIP_45        = 46603;   // floor(2^21 / 45)
    localparam int RECIP_SHIFT     = 21;
    localparam int FRAC_W          = 22;      // turn fraction below one 1/45 step
    localparam int CW              = 34;      // CORDIC datapath width
    localparam int TW              = 32;      // sine/cosine width out of CORDIC

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [TW-1:0] t_trig;
    typedef logic [FRAC_W-1:0]    t_frac_tab [DIV_45];
    typedef logic [31:0]          t_atan_tab [ATAN_COUNT];

    localparam t_atan_tab ATAN_TURNS = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // floor((m*2^22 + 22) / 45), built at elaboration
    function automatic t_frac_tab build_frac_tab();
        t_frac_tab tab;
        for (int i = 0; i < DIV_45; i++) begin
            tab[i] = FRAC_W'(((64'(i) << FRAC_W) + 64'd22) / DIV_45);
        end
        return tab;
    endfunction

    localparam t_frac_tab FRAC_TAB = build_frac_tab();

endpackage

// ===== hdl/eaq_turn.sv =====
// Angle to folded turn count: wrap, scale by 2^32/46080, quadrant fold.
// Two register stages. Depends on eaq_pkg.
module eaq_turn (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [15:0]  i_angle,
    output logic                o_valid,
    output logic signed [31:0]  o_z,
    output logic                o_neg
);
    import eaq_pkg::*;

    logic        r_v1, r_v2;
    logic [15:0] r_r, n_r;
    logic [10:0] r_q0, n_q0;
    logic [16:0] wrap_sum;
    logic [31:0] recip_prod;

    always_comb begin
        wrap_sum   = {i_angle[15], i_angle} + 17'(HALF_TURN_UNITS);
        n_r        = i_angle[15] ? wrap_sum[15:0] : i_angle;
        recip_prod = 32'(n_r) * 32'(RECIP_45);
        n_q0       = recip_prod[RECIP_SHIFT +: 11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_r  <= n_r;
        r_q0 <= n_q0;
    end

    logic [16:0]        prod45, diff;
    logic [6:0]         m_raw;
    logic [5:0]         m_idx;
    logic [10:0]        q;
    logic [31:0]        t;
    logic signed [31:0] zs, n_z;
    logic               n_neg;
    logic signed [31:0] r_z;
    logic               r_neg;

    always_comb begin
        prod45 = 17'(r_q0) * 17'(DIV_45);
        diff   = 17'(r_r) - prod45;
        m_raw  = diff[6:0];
        // reciprocal estimate may be one low
        if (m_raw >= 7'(DIV_45)) begin
            q     = r_q0 + 11'd1;
            m_idx = 6'(m_raw - 7'(DIV_45));
        end else begin
            q     = r_q0;
            m_idx = m_raw[5:0];
        end
        t  = {q[9:0], FRAC_TAB[m_idx]};
        zs = $signed(t);
        if (zs > 32'sd1073741824 || zs < -32'sd1073741824) begin
            n_z   = {~zs[31], zs[30:0]};   // +/- half turn
            n_neg = 1'b1;
        end else begin
            n_z   = zs;
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_z   <= n_z;
        r_neg <= n_neg;
    end

    assign o_valid = r_v2;
    assign o_z     = r_z;
    assign o_neg   = r_neg;
endmodule

// ===== hdl/eaq_cordic.sv =====
// Pipelined CORDIC rotation: one register stage per iteration, then sign fix.
// Depends on eaq_pkg.
module eaq_cordic #(
    parameter int STEPS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [31:0]         i_z,
    input  logic                       i_neg,
    output logic                       o_valid,
    output eaq_pkg::t_trig             o_cos,
    output eaq_pkg::t_trig             o_sin
);
    import eaq_pkg::*;

    t_cw  x [STEPS+1];
    t_cw  y [STEPS+1];
    t_cw  z [STEPS+1];
    logic v [STEPS+1];
    logic ng [STEPS+1];

    assign x[0]  = CORDIC_GAIN;
    assign y[0]  = '0;
    assign z[0]  = CW'(i_z);
    assign v[0]  = i_valid;
    assign ng[0] = i_neg;

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        t_cw dx, dy, n_x, n_y, n_zz;
        t_cw r_x, r_y, r_zz;
        logic r_v, r_ng;

        always_comb begin
            dx = y[i] >>> i;
            dy = x[i] >>> i;
            if (!z[i][CW-1]) begin
                n_x  = x[i] - dx;
                n_y  = y[i] + dy;
                n_zz = z[i] - CW'(ATAN_TURNS[i]);
            end else begin
                n_x  = x[i] + dx;
                n_y  = y[i] - dy;
                n_zz = z[i] + CW'(ATAN_TURNS[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= v[i];
            end
            r_x  <= n_x;
            r_y  <= n_y;
            r_zz <= n_zz;
            r_ng <= ng[i];
        end

        assign x[i+1]  = r_x;
        assign y[i+1]  = r_y;
        assign z[i+1]  = r_zz;
        assign v[i+1]  = r_v;
        assign ng[i+1] = r_ng;
    end

    t_cw   fx, fy;
    t_trig r_cos, r_sin;
    logic  r_ov;

    always_comb begin
        fx = ng[STEPS] ? -x[STEPS] : x[STEPS];
        fy = ng[STEPS] ? -y[STEPS] : y[STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= v[STEPS];
        end
        r_cos <= TW'(fx);
        r_sin <= TW'(fy);
    end

    assign o_valid = r_ov;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;
endmodule

// ===== hdl/eaq_combine.sv =====
// Hamilton product (Qx*Qy)*Qz from sines/cosines, round and saturate.
// Three register stages. Depends on eaq_pkg.
module eaq_combine #(
    parameter int FRAC_BITS = 15
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  eaq_pkg::t_trig            i_cx,
    input  eaq_pkg::t_trig            i_sx,
    input  eaq_pkg::t_trig            i_cy,
    input  eaq_pkg::t_trig            i_sy,
    input  eaq_pkg::t_trig            i_cz,
    input  eaq_pkg::t_trig            i_sz,
    output logic                      o_valid,
    output logic signed [FRAC_BITS:0] o_qx,
    output logic signed [FRAC_BITS:0] o_qy,
    output logic signed [FRAC_BITS:0] o_qz,
    output logic signed [FRAC_BITS:0] o_qw
);
    import eaq_pkg::*;

    localparam int SH = 2 * ITER_FRAC - FRAC_BITS;
    localparam int SW = 2 * TW + 2;

    // stage 1: pair products, Q2.30
    logic signed [2*TW-1:0] m_px, m_py, m_pz, m_pw;
    t_trig r_px, r_py, r_pz, r_pw, r_cz, r_sz;
    logic  r_v1, r_v2, r_v3;

    localparam logic signed [2*TW-1:0] HALF30 = (2*TW)'(64'd1 << (ITER_FRAC - 1));

    always_comb begin
        m_px = (i_sx * i_cy + HALF30) >>> ITER_FRAC;
        m_py = (i_cx * i_sy + HALF30) >>> ITER_FRAC;
        m_pz = (i_sx * i_sy + HALF30) >>> ITER_FRAC;
        m_pw = (i_cx * i_cy + HALF30) >>> ITER_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_px <= TW'(m_px);
        r_py <= TW'(m_py);
        r_pz <= TW'(m_pz);
        r_pw <= TW'(m_pw);
        r_cz <= i_cz;
        r_sz <= i_sz;
    end

    // stage 2: eight products
    logic signed [2*TW-1:0] r_a0, r_a1, r_b0, r_b1, r_c0, r_c1, r_d0, r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_a0 <= r_px * r_cz;
        r_a1 <= r_py * r_sz;
        r_b0 <= r_py * r_cz;
        r_b1 <= r_px * r_sz;
        r_c0 <= r_pw * r_sz;
        r_c1 <= r_pz * r_cz;
        r_d0 <= r_pw * r_cz;
        r_d1 <= r_pz * r_sz;
    end

    // stage 3: sum, round half up, saturate
    function automatic logic signed [FRAC_BITS:0] to_out(logic signed [SW-1:0] s);
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] hi, lo;
        hi = SW'((66'sd1 <<< FRAC_BITS) - 66'sd1);
        lo = -SW'(66'sd1 <<< FRAC_BITS);
        v  = (s + SW'(66'sd1 <<< (SH - 1))) >>> SH;
        if (v > hi) begin
            v = hi;
        end else if (v < lo) begin
            v = lo;
        end
        return v[FRAC_BITS:0];
    endfunction

    logic signed [FRAC_BITS:0] r_qx, r_qy, r_qz, r_qw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_qx <= to_out(SW'(r_a0) + SW'(r_a1));
        r_qy <= to_out(SW'(r_b0) - SW'(r_b1));
        r_qz <= to_out(SW'(r_c0) + SW'(r_c1));
        r_qw <= to_out(SW'(r_d0) - SW'(r_d1));
    end

    assign o_valid = r_v3;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_qz    = r_qz;
    assign o_qw    = r_qw;
endmodule

// ===== hdl/euler_angles_to_quaternion.sv =====
// Top level: Euler angles (X, Y, Z) to unit quaternion, fully pipelined.
// Depends on eaq_pkg, eaq_turn, eaq_cordic, eaq_combine.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+----------------------------
//  input     | i_angle_x, i_angle_y, i_angle_z         | start high, busy low
//  result    | o_quat_x, o_quat_y, o_quat_z, o_quat_w  | o_strobe, one cycle, no stall
//
// One beat in per cycle; busy is never raised, since nothing downstream can stall.
// The pipe runs angle wrap and turn scaling, then TRIG_STEPS CORDIC iteration stages
// plus 1 sign-fix stage, then the quaternion products.
// The CORDIC stage count sets the latency; throughput is always one beat a cycle.
// Synchronous active-low reset clears only the valid bits along the pipe.
module euler_angles_to_quaternion #(
    parameter int FRAC_BITS  = 15,
    parameter int TRIG_STEPS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [15:0]        i_angle_x,
    input  logic signed [15:0]        i_angle_y,
    input  logic signed [15:0]        i_angle_z,
    output logic                      o_strobe,
    output logic signed [FRAC_BITS:0] o_quat_x,
    output logic signed [FRAC_BITS:0] o_quat_y,
    output logic signed [FRAC_BITS:0] o_quat_z,
    output logic signed [FRAC_BITS:0] o_quat_w
);
    import eaq_pkg::*;

    logic               accept;
    logic               tv_x, tv_y, tv_z;
    logic signed [31:0] z_x, z_y, z_z;
    logic               ng_x, ng_y, ng_z;
    logic               cv_x, cv_y, cv_z;
    t_trig              cx, sx, cy, sy, cz, sz;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // angle -> folded turn count, one lane per axis
    eaq_turn u_turn_x (.i_clk, .i_rst_n, .i_valid(accept), .i_angle(i_angle_x),
                       .o_valid(tv_x), .o_z(z_x), .o_neg(ng_x));
    eaq_turn u_turn_y (.i_clk, .i_rst_n, .i_valid(accept), .i_angle(i_angle_y),
                       .o_valid(tv_y), .o_z(z_y), .o_neg(ng_y));
    eaq_turn u_turn_z (.i_clk, .i_rst_n, .i_valid(accept), .i_angle(i_angle_z),
                       .o_valid(tv_z), .o_z(z_z), .o_neg(ng_z));

    // half-angle sine/cosine; lanes run in lockstep, their valids are ANDed below
    eaq_cordic #(.STEPS(TRIG_STEPS)) u_cordic_x (
        .i_clk, .i_rst_n, .i_valid(tv_x), .i_z(z_x), .i_neg(ng_x),
        .o_valid(cv_x), .o_cos(cx), .o_sin(sx));
    eaq_cordic #(.STEPS(TRIG_STEPS)) u_cordic_y (
        .i_clk, .i_rst_n, .i_valid(tv_y), .i_z(z_y), .i_neg(ng_y),
        .o_valid(cv_y), .o_cos(cy), .o_sin(sy));
    eaq_cordic #(.STEPS(TRIG_STEPS)) u_cordic_z (
        .i_clk, .i_rst_n, .i_valid(tv_z), .i_z(z_z), .i_neg(ng_z),
        .o_valid(cv_z), .o_cos(cz), .o_sin(sz));

    eaq_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
        .i_clk, .i_rst_n,
        .i_valid(cv_x & cv_y & cv_z),
        .i_cx(cx), .i_sx(sx), .i_cy(cy), .i_sy(sy), .i_cz(cz), .i_sz(sz),
        .o_valid(o_strobe),
        .o_qx(o_quat_x), .o_qy(o_quat_y), .o_qz(o_quat_z), .o_qw(o_quat_w));
endmodule

// ===== tb/tb.sv =====
// Testbench for euler_angles_to_quaternion: random and directed angle triples,
// a self-contained CORDIC-based quaternion predictor, per-component checks.
// Depends on the RTL only (euler_angles_to_quaternion and eaq_pkg).
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 15;
    localparam int TRIG_STEPS = 16;
    localparam int LATENCY    = TRIG_STEPS + 6;
    localparam int WATCHDOG   = 4000;
    localparam int N_RANDOM   = 1630;

    typedef struct {
        logic signed [15:0] ax, ay, az;
    } t_angles;

    typedef struct {
        logic signed [FRAC_BITS:0] qx, qy, qz, qw;
    } t_quat;

    // atan(2^-i) in units of 2^-32 turn
    localparam longint ATAN_TURN [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465,  10679838,  5340245,   2670163,  1335087,
        667544,    333772,    166886,    83443,    41722,
        20861,     10430,     5215,      2608,     1304,
        652,       326,       163,       81,       41,
        20,        10,        5,         3,        1
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] i_angle_x = '0, i_angle_y = '0, i_angle_z = '0;
    logic o_strobe;
    logic signed [FRAC_BITS:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;

    t_angles pending_angles[$];
    t_quat   expected_quats[$];
    int      n_errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      idle_cycles = 0;
    int      gap_left = 0;
    bit      feeding_done = 0;

    euler_angles_to_quaternion #(
        .FRAC_BITS (FRAC_BITS),
        .TRIG_STEPS(TRIG_STEPS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_angle_x(i_angle_x),
        .i_angle_y(i_angle_y),
        .i_angle_z(i_angle_z),
        .o_strobe (o_strobe),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z),
        .o_quat_w (o_quat_w)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Arithmetic shift in SV on signed longint is already floor.
    function automatic void half_sin_cos(input logic signed [15:0] raw,
                                         output longint c, output longint s);
        longint r, z, x, y, dx, dy;
        longint unsigned t;
        bit flip;
        flip = 0;
        r = longint'(raw) % 46080;
        if (r < 0) r += 46080;
        t = ((unsigned'(r) << 32) + 64'd23040) / 64'd46080;
        t &= 64'hFFFF_FFFF;
        z = longint'(t);
        if (z >= (64'sd1 <<< 31)) z -= (64'sd1 <<< 32);
        // quadrant fold: bring angle into [-1/4, 1/4] turn
        if (z > (64'sd1 <<< 30)) begin
            z -= (64'sd1 <<< 31);
            flip = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += (64'sd1 <<< 31);
            flip = 1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < TRIG_STEPS && i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURN[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TURN[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [FRAC_BITS:0] round_sat(longint v60);
        int     sh;
        longint v, hi, lo;
        sh = 60 - FRAC_BITS;
        v = (v60 + (64'sd1 <<< (sh - 1))) >>> sh;
        hi = (64'sd1 <<< FRAC_BITS) - 1;
        lo = -(64'sd1 <<< FRAC_BITS);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[FRAC_BITS:0];
    endfunction

    function automatic t_quat predict_quat(t_angles a);
        longint cx, sx, cy, sy, cz, sz, px, py, pz, pw;
        t_quat q;
        half_sin_cos(a.ax, cx, sx);
        half_sin_cos(a.ay, cy, sy);
        half_sin_cos(a.az, cz, sz);
        px = q30_mul(sx, cy);
        py = q30_mul(cx, sy);
        pz = q30_mul(sx, sy);
        pw = q30_mul(cx, cy);
        q.qx = round_sat(px * cz + py * sz);
        q.qy = round_sat(py * cz - px * sz);
        q.qz = round_sat(pw * sz + pz * cz);
        q.qw = round_sat(pw * cz - pz * sz);
        return q;
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF - 16'($urandom_range(0, 3));
            1:       return 16'sh8000 + 16'($urandom_range(0, 3));
            2:       return 16'($urandom_range(0, 8)) * 16'd2880
                            + 16'($urandom_range(0, 2)) - 16'sd1; // near 45 deg steps
            3:       return 16'($urandom_range(0, 255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: a beat moves when start is high and busy is low at the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_quats.push_back(predict_quat(
                    '{ax: i_angle_x, ay: i_angle_y, az: i_angle_z}));
                n_sent++;
            end
            if (start && busy) begin
                // hold the current beat
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_angles.size() > 0) begin
                t_angles a;
                a = pending_angles.pop_front();
                i_angle_x <= a.ax;
                i_angle_y <= a.ay;
                i_angle_z <= a.az;
                start <= 1'b1;
                // stretches without gaps, then bursts of idling
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            end else begin
                start <= 1'b0;
                feeding_done <= 1'b1;
            end
        end
    end

    // Monitor: every strobe beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_quats.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d",
                         $time, o_quat_x, o_quat_y, o_quat_z, o_quat_w);
                n_errors++;
            end else begin
                t_quat q;
                q = expected_quats.pop_front();
                if (o_quat_x !== q.qx || o_quat_y !== q.qy
                        || o_quat_z !== q.qz || o_quat_w !== q.qw) begin
                    $display("%0t: quat mismatch exp (%0d %0d %0d %0d) got (%0d %0d %0d %0d)",
                             $time, q.qx, q.qy, q.qz, q.qw,
                             o_quat_x, o_quat_y, o_quat_z, o_quat_w);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // Watchdog: cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_angles a;
        logic signed [15:0] corners[8];
        corners = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd5760,
                    16'sd11520, -16'sd5760, 16'sd23040, 16'sh5555};
        // Directed: zero, full-scale, wrap past one turn, 90/180/360 deg, +1 saturation
        pending_angles.push_back('{16'sd0, 16'sd0, 16'sd0});
        pending_angles.push_back('{16'shFFFF, 16'shFFFF, 16'shFFFF});
        pending_angles.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF});
        pending_angles.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000});
        pending_angles.push_back('{16'sd23040, 16'sd0, 16'sd0});
        pending_angles.push_back('{16'sd0, -16'sd23040, 16'sd0});
        pending_angles.push_back('{16'sd0, 16'sd0, 16'sd11520});
        pending_angles.push_back('{16'sd5760, 16'sd5760, 16'sd5760});
        pending_angles.push_back('{-16'sd11520, 16'sd11520, -16'sd11520});
        pending_angles.push_back('{-16'sd19457, 16'sd1, -16'sd1});
        for (int i = 0; i < 8; i++) begin
            a.ax = corners[i];
            a.ay = corners[(i + 3) % 8];
            a.az = corners[(i + 5) % 8];
            pending_angles.push_back(a);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            a.ax = rand_angle();
            a.ay = rand_angle();
            a.az = rand_angle();
            pending_angles.push_back(a);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (feeding_done && expected_quats.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Covered %0d angle triples, %0d quaternions checked, %0d mismatches.",
                 n_sent, n_checked, n_errors);
        if (n_errors == 0 && expected_quats.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
